FILE: sv/pcf_pkg.sv
`timescale 1ns / 1ps

package pcf_pkg;

  typedef enum logic [2:0] {
    PH_SIG  = 3'd0,
    PH_LEN  = 3'd1,
    PH_TYPE = 3'd2,
    PH_DATA = 3'd3,
    PH_CRC  = 3'd4,
    PH_END  = 3'd5,
    PH_ERR  = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    KIND_OTHER = 3'd0,
    KIND_IHDR  = 3'd1,
    KIND_IDAT  = 3'd2,
    KIND_PHYS  = 3'd3,
    KIND_IEND  = 3'd4
  } kind_t;

  localparam logic [31:0] TAG_IHDR = {8'd73, 8'd72, 8'd68, 8'd82};
  localparam logic [31:0] TAG_IDAT = {8'd73, 8'd68, 8'd65, 8'd84};
  localparam logic [31:0] TAG_PHYS = {8'd112, 8'd72, 8'd89, 8'd115};
  localparam logic [31:0] TAG_IEND = {8'd73, 8'd69, 8'd78, 8'd68};

  localparam logic [2:0] SIG_LAST = 3'd7;
  localparam logic [2:0] FIELD_LAST = 3'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       restart;
  } pcf_item_t;

  typedef struct packed {
    logic [2:0]  byte_phase;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        type_done;
    logic [2:0]  chunk_kind;
    logic [31:0] chunk_length;
    logic        stream_done;
    logic        bad_signature;
    logic        trailing_byte;
  } pcf_result_t;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  field_count;
    logic [31:0] length_accum;
    logic [31:0] payload_left;
    logic [23:0] type_shift;
    kind_t       kind;
    logic        sig_err;
  } pcf_state_t;

  localparam pcf_state_t PCF_STATE_RESET = '{
    phase:        PH_SIG,
    field_count:  3'd0,
    length_accum: 32'd0,
    payload_left: 32'd0,
    type_shift:   24'd0,
    kind:         KIND_OTHER,
    sig_err:      1'b0
  };

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0: b = 8'h89;
      3'd1: b = 8'h50;
      3'd2: b = 8'h4E;
      3'd3: b = 8'h47;
      3'd4: b = 8'h0D;
      3'd5: b = 8'h0A;
      3'd6: b = 8'h1A;
      default: b = 8'h0A;
    endcase
    return b;
  endfunction

  function automatic kind_t classify(input logic [31:0] tag);
    kind_t k;
    priority if (tag == TAG_IHDR) k = KIND_IHDR;
    else if (tag == TAG_IDAT) k = KIND_IDAT;
    else if (tag == TAG_PHYS) k = KIND_PHYS;
    else if (tag == TAG_IEND) k = KIND_IEND;
    else k = KIND_OTHER;
    return k;
  endfunction

endpackage

FILE: sv/pcf_step.sv
`timescale 1ns / 1ps

module pcf_step (
  input  pcf_pkg::pcf_state_t  state,
  input  pcf_pkg::pcf_item_t   item,
  output pcf_pkg::pcf_state_t  state_next,
  output pcf_pkg::pcf_result_t res
);
  import pcf_pkg::*;

  pcf_state_t  cur;
  logic [7:0]  b;
  logic [31:0] len_new;
  logic [31:0] left_dec;

  assign b = item.in_byte;
  assign left_dec = cur.payload_left - 32'd1;

  always_comb begin
    // restart acts before the byte is taken
    cur = item.restart ? PCF_STATE_RESET : state;
    state_next = cur;
    res = '0;
    res.byte_phase = cur.phase;
    len_new = {cur.length_accum[23:0], b};

    unique case (cur.phase)
      PH_SIG: begin
        if (b != sig_byte(cur.field_count)) begin
          state_next.sig_err = 1'b1;
          state_next.phase = PH_ERR;
          state_next.field_count = 3'd0;
        end else if (cur.field_count == SIG_LAST) begin
          state_next.phase = PH_LEN;
          state_next.field_count = 3'd0;
        end else begin
          state_next.field_count = cur.field_count + 3'd1;
        end
      end
      PH_LEN: begin
        if (cur.field_count == 3'd0) begin
          len_new = {24'd0, b};
          state_next.kind = KIND_OTHER;
        end
        state_next.length_accum = len_new;
        res.chunk_length = len_new;
        if (cur.field_count >= FIELD_LAST) begin
          state_next.phase = PH_TYPE;
          state_next.field_count = 3'd0;
          state_next.payload_left = len_new;
          state_next.type_shift = 24'd0;
        end else begin
          state_next.field_count = cur.field_count + 3'd1;
        end
      end
      PH_TYPE: begin
        if (cur.field_count >= FIELD_LAST) begin
          state_next.kind = classify({cur.type_shift, b});
          res.type_done = 1'b1;
          // zero-length chunk goes straight to the crc
          state_next.phase = (cur.payload_left == 32'd0) ? PH_CRC : PH_DATA;
          state_next.field_count = 3'd0;
        end else begin
          state_next.type_shift = {cur.type_shift[15:0], b};
          state_next.field_count = cur.field_count + 3'd1;
        end
        res.chunk_kind = state_next.kind;
        res.chunk_length = cur.length_accum;
      end
      PH_DATA: begin
        res.payload_valid = 1'b1;
        res.payload_byte = b;
        res.chunk_kind = cur.kind;
        res.chunk_length = cur.length_accum;
        state_next.payload_left = left_dec;
        if (left_dec == 32'd0) begin
          state_next.phase = PH_CRC;
          state_next.field_count = 3'd0;
        end
      end
      PH_CRC: begin
        res.chunk_kind = cur.kind;
        res.chunk_length = cur.length_accum;
        if (cur.field_count >= FIELD_LAST) begin
          state_next.field_count = 3'd0;
          if (cur.kind == KIND_IEND) begin
            res.stream_done = 1'b1;
            state_next.phase = PH_END;
          end else begin
            state_next.phase = PH_LEN;
          end
        end else begin
          state_next.field_count = cur.field_count + 3'd1;
        end
      end
      PH_END: begin
        res.chunk_kind = cur.kind;
        res.chunk_length = cur.length_accum;
        res.trailing_byte = 1'b1;
      end
      default: begin
        res.byte_phase = PH_ERR;
        res.trailing_byte = 1'b1;
        state_next.phase = PH_ERR;
      end
    endcase

    res.bad_signature = state_next.sig_err;
  end

endmodule

FILE: sv/pcf_out_buf.sv
`timescale 1ns / 1ps

module pcf_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  pcf_pkg::pcf_result_t load_data,
  output logic                 can_load,
  output logic                 result_valid,
  input  logic                 result_ready,
  output pcf_pkg::pcf_result_t result
);
  import pcf_pkg::*;

  logic full;

  assign can_load = !full || result_ready;
  assign result_valid = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (can_load) begin
      full <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      result <= load_data;
    end
  end

endmodule

FILE: sv/png_chunk_framer.sv
`timescale 1ns / 1ps

// channel  | handshake                  | payload
// ---------+----------------------------+-----------------------------
// feed     | feed_valid / feed_ready    | feed   (pcf_item_t: byte, restart)
// result   | result_valid / result_ready| result (pcf_result_t)
//
// one byte per clock sustained while results are taken; a byte's result is
// presented once it moves from the input register into the result register
// parser state advances when the registered byte moves into the result register
// rst clears the parser to the signature check and empties both registers
// a stalled result holds the pipe; feed_ready drops only when both stages are full

module png_chunk_framer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 feed_valid,
  output logic                 feed_ready,
  input  pcf_pkg::pcf_item_t   feed,
  output logic                 result_valid,
  input  logic                 result_ready,
  output pcf_pkg::pcf_result_t result
);
  import pcf_pkg::*;

  logic        feed_full;
  pcf_item_t   feed_q;
  pcf_state_t  state;
  pcf_state_t  state_next;
  pcf_result_t step_res;
  logic        can_load;
  logic        advance;

  assign advance = feed_full && can_load;
  assign feed_ready = !feed_full || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      feed_full <= 1'b0;
    end else if (feed_ready) begin
      feed_full <= feed_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (feed_valid && feed_ready) begin
      feed_q <= feed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PCF_STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  pcf_step u_step (
    .state      (state),
    .item       (feed_q),
    .state_next (state_next),
    .res        (step_res)
  );

  pcf_out_buf u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (feed_full),
    .load_data    (step_res),
    .can_load     (can_load),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

FILE: sv/pcf_checker.sv
`timescale 1ns / 1ps

module pcf_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 result_valid,
  input logic                 result_ready,
  input pcf_pkg::pcf_result_t result
);
  import pcf_pkg::*;

  // a held result must not change
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  a_payload: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.payload_valid |-> result.byte_phase == PH_DATA)
    else $error("payload flagged outside data phase");

  a_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.stream_done |->
      result.byte_phase == PH_CRC && result.chunk_kind == KIND_IEND)
    else $error("stream done outside iend crc");

  a_trail: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.trailing_byte |->
      result.byte_phase == PH_END || result.byte_phase == PH_ERR)
    else $error("trailing byte in a live phase");

  a_err: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.byte_phase == PH_ERR |->
      result.bad_signature && result.chunk_length == 32'd0)
    else $error("error phase without signature error");

endmodule

bind png_chunk_framer pcf_checker u_pcf_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import pcf_pkg::*;

  localparam logic [63:0] PNG_MAGIC = 64'h89504E470D0A1A0A;
  localparam int BYTE_TARGET = 1500;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        feed_valid = 1'b0;
  logic        feed_ready;
  pcf_item_t   feed = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  pcf_result_t result;

  png_chunk_framer u_top (
    .clk          (clk),
    .rst          (rst),
    .feed_valid   (feed_valid),
    .feed_ready   (feed_ready),
    .feed         (feed),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // byte stream waiting to be driven, and the results it should produce
  pcf_item_t   pending_items[$];
  pcf_result_t expected_results[$];
  logic [7:0]  stream_bytes[$];

  // framer model state
  phase_t      fr_phase;
  logic [2:0]  fr_count;
  logic [31:0] len_acc;
  logic [31:0] bytes_left;
  logic [23:0] tag_hist;
  kind_t       fr_kind;
  logic        sig_bad;

  int bytes_framed = 0;
  int payload_bytes = 0;
  int ends_reached = 0;
  int sig_errors = 0;
  int streams_sent = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  int burst_left = 8;
  int gap_left = 0;
  int stall_mode = 0;
  int mode_cycles = 0;
  logic [15:0] stall_mask = 16'hFFFF;

  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    return PNG_MAGIC[8 * (7 - int'(idx)) +: 8];
  endfunction

  function automatic kind_t tag_kind(input logic [31:0] tag);
    case (tag)
      TAG_IHDR: return KIND_IHDR;
      TAG_IDAT: return KIND_IDAT;
      TAG_PHYS: return KIND_PHYS;
      TAG_IEND: return KIND_IEND;
      default:  return KIND_OTHER;
    endcase
  endfunction

  task automatic clear_framer();
    fr_phase = PH_SIG;
    fr_count = '0;
    len_acc = '0;
    bytes_left = '0;
    tag_hist = '0;
    fr_kind = KIND_OTHER;
    sig_bad = 1'b0;
  endtask

  task automatic frame_byte(input pcf_item_t it);
    pcf_result_t r;
    logic [7:0] b;
    b = it.in_byte;
    r = '0;
    if (it.restart) clear_framer();
    r.byte_phase = fr_phase;
    case (fr_phase)
      PH_SIG: begin
        if (b != magic_byte(fr_count)) begin
          sig_bad = 1'b1;
          sig_errors++;
          fr_phase = PH_ERR;
          fr_count = '0;
        end else if (fr_count == SIG_LAST) begin
          fr_phase = PH_LEN;
          fr_count = '0;
        end else begin
          fr_count = fr_count + 3'd1;
        end
      end
      PH_LEN: begin
        if (fr_count == 3'd0) begin
          len_acc = {24'd0, b};
          fr_kind = KIND_OTHER;
        end else begin
          len_acc = {len_acc[23:0], b};
        end
        r.chunk_length = len_acc;
        if (fr_count == FIELD_LAST) begin
          fr_phase = PH_TYPE;
          fr_count = '0;
          bytes_left = len_acc;
          tag_hist = '0;
        end else begin
          fr_count = fr_count + 3'd1;
        end
      end
      PH_TYPE: begin
        if (fr_count == FIELD_LAST) begin
          fr_kind = tag_kind({tag_hist, b});
          r.type_done = 1'b1;
          fr_phase = (bytes_left == 32'd0) ? PH_CRC : PH_DATA;
          fr_count = '0;
        end else begin
          tag_hist = {tag_hist[15:0], b};
          fr_count = fr_count + 3'd1;
        end
        r.chunk_kind = fr_kind;
        r.chunk_length = len_acc;
      end
      PH_DATA: begin
        r.payload_valid = 1'b1;
        r.payload_byte = b;
        r.chunk_kind = fr_kind;
        r.chunk_length = len_acc;
        payload_bytes++;
        bytes_left = bytes_left - 32'd1;
        if (bytes_left == 32'd0) begin
          fr_phase = PH_CRC;
          fr_count = '0;
        end
      end
      PH_CRC: begin
        r.chunk_kind = fr_kind;
        r.chunk_length = len_acc;
        if (fr_count == FIELD_LAST) begin
          fr_count = '0;
          if (fr_kind == KIND_IEND) begin
            r.stream_done = 1'b1;
            ends_reached++;
            fr_phase = PH_END;
          end else begin
            fr_phase = PH_LEN;
          end
        end else begin
          fr_count = fr_count + 3'd1;
        end
      end
      PH_END: begin
        r.chunk_kind = fr_kind;
        r.chunk_length = len_acc;
        r.trailing_byte = 1'b1;
      end
      default: begin
        r.byte_phase = PH_ERR;
        r.trailing_byte = 1'b1;
        fr_phase = PH_ERR;
      end
    endcase
    r.bad_signature = sig_bad;
    bytes_framed++;
    expected_results.push_back(r);
  endtask

  task automatic push_be32(input logic [31:0] v);
    for (int i = 3; i >= 0; i--) stream_bytes.push_back(v[8 * i +: 8]);
  endtask

  task automatic push_sig();
    for (int i = 0; i < 8; i++) stream_bytes.push_back(magic_byte(3'(i)));
  endtask

  // length and type, n_data random bytes, then four random crc bytes
  task automatic push_chunk(input logic [31:0] len, input logic [31:0] tag, input int n_data);
    push_be32(len);
    push_be32(tag);
    repeat (n_data) stream_bytes.push_back(8'($urandom));
    repeat (4) stream_bytes.push_back(8'($urandom));
  endtask

  task automatic send_stream(input int keep, input logic rs);
    pcf_item_t it;
    for (int i = 0; i < keep; i++) begin
      it.in_byte = stream_bytes[i];
      it.restart = (i == 0) && rs;
      pending_items.push_back(it);
    end
    stream_bytes.delete();
    streams_sent++;
  endtask

  // mostly known tags, with near misses and random tags mixed in
  function automatic logic [31:0] pick_tag();
    case ($urandom_range(0, 9))
      0, 1:    return TAG_IHDR;
      2, 3, 4: return TAG_IDAT;
      5:       return TAG_PHYS;
      6:       return TAG_IEND ^ (32'd1 << $urandom_range(0, 31));
      7:       return TAG_IDAT ^ (32'd1 << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  task automatic report_bad(input string what, input pcf_result_t want, input pcf_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%t %s", $realtime, what);
      $display("  want ph=%0d pv=%0b pb=%02h td=%0b k=%0d len=%08h dn=%0b bs=%0b tr=%0b",
               want.byte_phase, want.payload_valid, want.payload_byte, want.type_done,
               want.chunk_kind, want.chunk_length, want.stream_done, want.bad_signature,
               want.trailing_byte);
      $display("  got  ph=%0d pv=%0b pb=%02h td=%0b k=%0d len=%08h dn=%0b bs=%0b tr=%0b",
               got.byte_phase, got.payload_valid, got.payload_byte, got.type_done,
               got.chunk_kind, got.chunk_length, got.stream_done, got.bad_signature,
               got.trailing_byte);
    end
  endtask

  // sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      feed_valid <= 1'b0;
      clear_framer();
    end else begin
      if (feed_valid && feed_ready) frame_byte(feed);
      if (!feed_valid || feed_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          feed_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          feed <= pending_items.pop_front();
          feed_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          feed_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: switches between always ready, random stalls and a rotating mask
  always @(posedge clk) begin : result_monitor
    pcf_result_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          report_bad("unexpected result item", '0, result);
        end else begin
          want = expected_results.pop_front();
          if (result !== want) report_bad("result item mismatch", want, result);
        end
      end
      mode_cycles++;
      if (mode_cycles == 150) begin
        mode_cycles = 0;
        stall_mode = $urandom_range(0, 2);
        stall_mask = 16'($urandom) | 16'h0001;
      end
      stall_mask = {stall_mask[14:0], stall_mask[15]};
      case (stall_mode)
        0:       result_ready <= 1'b1;
        1:       result_ready <= ($urandom_range(0, 9) < 7);
        default: result_ready <= stall_mask[0];
      endcase
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int mode;
    int k;
    int keep;
    logic [31:0] len;
    logic [7:0] b;

    // short file with an empty end chunk, a trailing byte, then a bad restart
    push_sig();
    push_chunk(32'd0, TAG_IEND, 0);
    stream_bytes.push_back(8'hFF);
    send_stream(stream_bytes.size(), 1'b0);
    stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'hFF);
    send_stream(stream_bytes.size(), 1'b1);

    while (pending_items.size() < BYTE_TARGET) begin
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
        k = $urandom_range(0, 7);
        for (int i = 0; i < k; i++) stream_bytes.push_back(magic_byte(3'(i)));
        b = 8'($urandom);
        if (b == magic_byte(3'(k))) b = ~b;
        stream_bytes.push_back(b);
        repeat ($urandom_range(0, 4)) stream_bytes.push_back(8'($urandom));
      end else begin
        push_sig();
        if (mode == 1) begin
          // full 32-bit length, cut short by the next stream
          push_chunk($urandom, pick_tag(), $urandom_range(0, 6));
        end else begin
          repeat ($urandom_range(0, 4)) begin
            len = ($urandom_range(0, 7) != 0) ? $urandom_range(0, 6) : $urandom_range(7, 40);
            push_chunk(len, pick_tag(), len);
          end
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
          push_chunk(len, TAG_IEND, len);
          repeat ($urandom_range(0, 3)) stream_bytes.push_back(8'($urandom));
        end
      end
      keep = stream_bytes.size();
      if (mode == 2 || mode == 3) keep = $urandom_range(1, keep);
      send_stream(keep, $urandom_range(0, 9) != 0);
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || feed_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_results.size() != 0) begin
      mismatch_count++;
      $display("%0d result items never arrived", expected_results.size());
    end
    $display("framed %0d bytes in %0d streams, %0d of them payload",
             bytes_framed, streams_sent, payload_bytes);
    $display("%0d stream ends, %0d signature errors, %0d mismatches",
             ends_reached, sig_errors, mismatch_count);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/pcf_pkg.sv
sv/pcf_step.sv
sv/pcf_out_buf.sv
sv/png_chunk_framer.sv
sv/pcf_checker.sv
tb/sv/tb.sv
